>>> rtl/assert_macros.svh
// Assertion macros used by the checker file tspq_checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define AST_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication with the consequent in the following cycle.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Check that also holds through reset.
`define AST_RAW(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/tspq_pkg.sv
// Package for the triangle simplex point query unit: item kinds and sequencer states.
// No dependencies.
package tspq_pkg;

    localparam logic [1:0] KIND_ADD     = 2'd0;
    localparam logic [1:0] KIND_CLOSEST = 2'd1;
    localparam logic [1:0] KIND_CONTAIN = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_DEC,
        ST_DIVX,
        ST_DIVY,
        ST_DIST,
        ST_CMP,
        ST_OUT
    } t_state;

endpackage

>>> rtl/tspq_muldiv.sv
// Bit-serial floor(mag * t / den) for t < den, one bit of mag per cycle.
// Depends on nothing.
module tspq_muldiv #(
    parameter int CW = 16,
    parameter int WW = 35
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [CW-1:0] i_mag,
    input  logic [WW-1:0] i_t,
    input  logic [WW-1:0] i_den,
    output logic          o_done,
    output logic [CW-1:0] o_q
);

    localparam int IW = $clog2(CW + 1);

    logic          r_busy;
    logic          r_done;
    logic [IW-1:0] r_i;
    logic [CW-1:0] r_mag;
    logic [WW-1:0] r_t;
    logic [WW-1:0] r_den;
    logic [WW-1:0] r_r;
    logic [CW-1:0] r_q;
    logic [WW-1:0] n_r;
    logic [CW-1:0] n_q;
    logic [WW-1:0] v_r;

    always_comb begin
        v_r = {r_r[WW-2:0], 1'b0};
        n_q = {r_q[CW-2:0], 1'b0};
        if (v_r >= r_den) begin
            v_r = v_r - r_den;
            n_q = n_q + CW'(1);
        end
        if (r_mag[CW-1]) begin
            v_r = v_r + r_t;
            if (v_r >= r_den) begin
                v_r = v_r - r_den;
                n_q = n_q + CW'(1);
            end
        end
        n_r = v_r;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_i == IW'(CW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_start) begin
            r_i   <= '0;
            r_mag <= i_mag;
            r_t   <= i_t;
            r_den <= i_den;
            r_r   <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            r_i   <= r_i + IW'(1);
            r_mag <= {r_mag[CW-2:0], 1'b0};
            r_r   <= n_r;
            r_q   <= n_q;
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule

>>> rtl/triangle_simplex_point_query_unit.sv
// Triangle simplex point query unit: window of three vertices, closest and containment queries.
// An add is taken in ST_IDLE; a query with fewer than two vertices goes straight to ST_OUT.
// Otherwise each edge runs ST_LOAD and ST_MUL (6 products on the shared multiplier), then
// ST_DEC; a closest query then runs two serial divisions (ST_DIVX, ST_DIVY) when the point
// projects inside the edge, and ST_DIST and ST_CMP, before the next edge or ST_OUT.
// One item at a time; ready only while idle. Synchronous active-low reset empties the window.
// Depends on tspq_pkg and tspq_muldiv.
module triangle_simplex_point_query_unit
    import tspq_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_kind,
    input  logic signed [COORD_BITS-1:0] i_x_coord,
    input  logic signed [COORD_BITS-1:0] i_y_coord,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [COORD_BITS-1:0] o_closest_x,
    output logic signed [COORD_BITS-1:0] o_closest_y,
    output logic                         o_inside_res,
    output logic [1:0]                   o_vertex_count
);

    localparam int C  = COORD_BITS;
    localparam int DW = C + 1;
    localparam int PW = 2 * C + 2;
    localparam int W  = 2 * C + 3;

    t_state r_state, n_state;

    logic signed [C-1:0]  r_vx [3];
    logic signed [C-1:0]  r_vy [3];
    logic [1:0]           r_count;
    logic [1:0]           r_kind;
    logic signed [C-1:0]  r_px, r_py;
    logic signed [C-1:0]  r_wx [3];
    logic signed [C-1:0]  r_wy [3];
    logic [1:0]           r_edge;
    logic                 r_first;
    logic [2:0]           r_cnt;
    logic signed [DW-1:0] r_dx, r_dy, r_qx, r_qy;
    logic signed [PW-1:0] r_prod;
    logic signed [W-1:0]  r_t, r_l2, r_cr, r_d, r_bd;
    logic                 r_s0z, r_s0n;
    logic signed [C-1:0]  r_cx, r_cy, r_bx, r_by;
    logic                 r_rin;
    logic                 r_ovalid;
    logic signed [C-1:0]  r_ox, r_oy;
    logic                 r_oin;
    logic [1:0]           r_ocnt;

    logic                 in_xfer;
    logic                 last_edge;
    logic                 div_start;
    logic                 div_done;
    logic [C-1:0]         div_q;
    logic [C-1:0]         div_mag;
    logic signed [DW-1:0] op_a, op_b;
    logic signed [DW-1:0] ex, ey;
    logic signed [DW-1:0] qsel;
    logic signed [DW-1:0] dsel;
    logic signed [DW-1:0] msel;
    logic signed [DW-1:0] cand;
    logic signed [W-1:0]  prod_w;
    logic                 cr_zero, cr_neg;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign last_edge  = (r_count == 2'd2) || (r_edge == 2'd2);
    assign cr_zero    = (r_cr == '0);
    assign cr_neg     = r_cr[W-1];
    assign prod_w     = {r_prod[PW-1], r_prod};
    assign ex         = DW'(r_cx) - DW'(r_px);
    assign ey         = DW'(r_cy) - DW'(r_py);

    always_comb begin
        op_a = ex;
        op_b = ex;
        if (r_state == ST_MUL) begin
            unique case (r_cnt)
                3'd0:    begin op_a = r_dx; op_b = r_qx; end
                3'd1:    begin op_a = r_dy; op_b = r_qy; end
                3'd2:    begin op_a = r_dx; op_b = r_dx; end
                3'd3:    begin op_a = r_dy; op_b = r_dy; end
                3'd4:    begin op_a = r_dx; op_b = r_qy; end
                default: begin op_a = r_dy; op_b = r_qx; end
            endcase
        end else if (r_cnt == 3'd1) begin
            op_a = ey;
            op_b = ey;
        end
    end

    // x division starts from ST_DEC, y division from ST_DIVX
    assign msel    = (r_state == ST_DIVX) ? r_dy : r_dx;
    assign div_mag = msel[DW-1] ? C'(-msel) : C'(msel);
    assign dsel    = (r_state == ST_DIVX) ? r_dx : r_dy;
    assign qsel    = dsel[DW-1] ? -DW'({1'b0, div_q}) : DW'({1'b0, div_q});
    assign cand    = DW'(r_wx[0]) + qsel;

    tspq_muldiv #(
        .CW (C),
        .WW (W)
    ) u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_mag   (div_mag),
        .i_t     (W'(r_t)),
        .i_den   (W'(r_l2)),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer && (i_kind == KIND_CLOSEST || i_kind == KIND_CONTAIN)) begin
                    n_state = (r_count < 2'd2) ? ST_OUT : ST_LOAD;
                end
            end
            ST_LOAD: n_state = ST_MUL;
            ST_MUL: begin
                if (r_cnt == 3'd6) n_state = ST_DEC;
            end
            ST_DEC: begin
                if (r_kind == KIND_CONTAIN) begin
                    if (r_count == 2'd2) begin
                        n_state = ST_OUT;
                    end else if (r_edge == 2'd0) begin
                        n_state = ST_LOAD;
                    end else if (cr_zero || cr_neg != r_s0n || r_s0z || r_edge == 2'd2) begin
                        n_state = ST_OUT;
                    end else begin
                        n_state = ST_LOAD;
                    end
                end else if (r_l2 <= r_t || r_t <= 0) begin
                    n_state = ST_DIST;
                end else begin
                    div_start = 1'b1;
                    n_state   = ST_DIVX;
                end
            end
            ST_DIVX: begin
                if (div_done) begin
                    div_start = 1'b1;
                    n_state   = ST_DIVY;
                end
            end
            ST_DIVY: begin
                if (div_done) n_state = ST_DIST;
            end
            ST_DIST: begin
                if (r_cnt == 3'd2) n_state = ST_CMP;
            end
            ST_CMP:  n_state = last_edge ? ST_OUT : ST_LOAD;
            ST_OUT: begin
                if (!r_ovalid || i_out_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= 2'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_ovalid && i_out_ready) r_ovalid <= 1'b0;
            if (r_state == ST_OUT && (!r_ovalid || i_out_ready)) r_ovalid <= 1'b1;
            if (in_xfer && i_kind == KIND_ADD) begin
                if (r_count == 2'd3) begin
                    r_vx[0] <= r_vx[1];
                    r_vy[0] <= r_vy[1];
                    r_vx[1] <= r_vx[2];
                    r_vy[1] <= r_vy[2];
                    r_vx[2] <= i_x_coord;
                    r_vy[2] <= i_y_coord;
                end else begin
                    unique case (r_count)
                        2'd0:    begin r_vx[0] <= i_x_coord; r_vy[0] <= i_y_coord; end
                        2'd1:    begin r_vx[1] <= i_x_coord; r_vy[1] <= i_y_coord; end
                        default: begin r_vx[2] <= i_x_coord; r_vy[2] <= i_y_coord; end
                    endcase
                    r_count <= r_count + 2'd1;
                end
            end
        end

        r_prod <= op_a * op_b;

        unique case (r_state)
            ST_IDLE: begin
                r_cnt   <= '0;
                r_kind  <= i_kind;
                r_px    <= i_x_coord;
                r_py    <= i_y_coord;
                r_first <= 1'b1;
                r_rin   <= 1'b0;
                r_bx    <= '0;
                r_by    <= '0;
                if (r_count == 2'd1) begin
                    if (i_kind == KIND_CLOSEST) begin
                        r_bx <= r_vx[0];
                        r_by <= r_vy[0];
                    end else begin
                        r_rin <= (i_x_coord == r_vx[0]) && (i_y_coord == r_vy[0]);
                    end
                end
                if (r_count == 2'd3) begin
                    r_wx[0] <= r_vx[2]; r_wy[0] <= r_vy[2];
                    r_wx[1] <= r_vx[0]; r_wy[1] <= r_vy[0];
                    r_wx[2] <= r_vx[1]; r_wy[2] <= r_vy[1];
                    r_edge  <= 2'd0;
                end else begin
                    r_wx[0] <= r_vx[0]; r_wy[0] <= r_vy[0];
                    r_wx[1] <= r_vx[1]; r_wy[1] <= r_vy[1];
                    r_wx[2] <= r_vx[2]; r_wy[2] <= r_vy[2];
                    r_edge  <= 2'd1;
                end
            end
            ST_LOAD: begin
                r_cnt <= '0;
                r_dx  <= DW'(r_wx[1]) - DW'(r_wx[0]);
                r_dy  <= DW'(r_wy[1]) - DW'(r_wy[0]);
                r_qx  <= DW'(r_px) - DW'(r_wx[0]);
                r_qy  <= DW'(r_py) - DW'(r_wy[0]);
            end
            ST_MUL: begin
                r_cnt <= r_cnt + 3'd1;
                unique case (r_cnt)
                    3'd1:    r_t  <= prod_w;
                    3'd2:    r_t  <= r_t + prod_w;
                    3'd3:    r_l2 <= prod_w;
                    3'd4:    r_l2 <= r_l2 + prod_w;
                    3'd5:    r_cr <= prod_w;
                    3'd6:    r_cr <= r_cr - prod_w;
                    default: ;
                endcase
            end
            ST_DEC: begin
                r_cnt <= '0;
                if (r_kind == KIND_CONTAIN) begin
                    if (r_count == 2'd2) begin
                        r_rin <= cr_zero && (r_t >= 0) && (r_t <= r_l2);
                    end else if (r_edge == 2'd0) begin
                        r_s0z <= cr_zero;
                        r_s0n <= cr_neg;
                    end else if (cr_zero) begin
                        r_rin <= 1'b1;
                    end else if (cr_neg != r_s0n || r_s0z) begin
                        r_rin <= 1'b0;
                    end else begin
                        r_rin <= 1'b1;
                    end
                    r_wx[0] <= r_wx[1]; r_wy[0] <= r_wy[1];
                    r_wx[1] <= r_wx[2]; r_wy[1] <= r_wy[2];
                    r_wx[2] <= r_wx[0]; r_wy[2] <= r_wy[0];
                    r_edge  <= r_edge + 2'd1;
                end else if (r_l2 <= r_t) begin
                    r_cx <= r_wx[1];
                    r_cy <= r_wy[1];
                end else begin
                    r_cx <= r_wx[0];
                    r_cy <= r_wy[0];
                end
            end
            ST_DIVX: begin
                if (div_done) r_cx <= C'(cand);
            end
            ST_DIVY: begin
                r_cnt <= '0;
                if (div_done) r_cy <= C'(DW'(r_wy[0]) + qsel);
            end
            ST_DIST: begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd1) r_d <= prod_w;
                if (r_cnt == 3'd2) r_d <= r_d + prod_w;
            end
            ST_CMP: begin
                r_first <= 1'b0;
                if (r_first || r_bd > r_d) begin
                    r_bx <= r_cx;
                    r_by <= r_cy;
                    r_bd <= r_d;
                end
                r_wx[0] <= r_wx[1]; r_wy[0] <= r_wy[1];
                r_wx[1] <= r_wx[2]; r_wy[1] <= r_wy[2];
                r_wx[2] <= r_wx[0]; r_wy[2] <= r_wy[0];
                r_edge  <= r_edge + 2'd1;
            end
            ST_OUT: begin
                if (!r_ovalid || i_out_ready) begin
                    r_ox   <= r_bx;
                    r_oy   <= r_by;
                    r_oin  <= r_rin;
                    r_ocnt <= r_count;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid    = r_ovalid;
    assign o_closest_x    = r_ox;
    assign o_closest_y    = r_oy;
    assign o_inside_res   = r_oin;
    assign o_vertex_count = r_ocnt;

endmodule

>>> rtl/tspq_checker.sv
// Port-level checks for the triangle simplex point query unit, bound to the top level.
// Depends on tspq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tspq_checker
    import tspq_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic [1:0]                   i_kind,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic signed [COORD_BITS-1:0] o_closest_x,
    input logic signed [COORD_BITS-1:0] o_closest_y,
    input logic                         o_inside_res,
    input logic [1:0]                   o_vertex_count
);

    `AST_RAW(a_reset_no_out, i_clk, !$past(i_rst_n), !o_out_valid)
    `AST_IMPLY(a_inside_zero_pt, i_clk, i_rst_n, o_out_valid && o_inside_res, o_closest_x == 0 && o_closest_y == 0)
    `AST_IMPLY(a_empty_answer, i_clk, i_rst_n, o_out_valid && o_vertex_count == 2'd0, o_closest_x == 0 && o_closest_y == 0 && !o_inside_res)
    `AST_NEXT(a_add_silent, i_clk, i_rst_n, i_in_valid && o_in_ready && i_kind == KIND_ADD && !o_out_valid, !o_out_valid)
    `AST_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_closest_x) && $stable(o_inside_res))

endmodule

bind triangle_simplex_point_query_unit tspq_checker #(.COORD_BITS(COORD_BITS)) u_tspq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .i_kind         (i_kind),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_closest_x    (o_closest_x),
    .o_closest_y    (o_closest_y),
    .o_inside_res   (o_inside_res),
    .o_vertex_count (o_vertex_count)
);

>>> bench/triangle_simplex_point_query_unit_test.sv
// Testbench for triangle_simplex_point_query_unit: vertex window, closest and containment queries.
// Predicts every answer with an integer model of the window and checks transfers in order.
// Depends on tspq_pkg and the unit's RTL.
`timescale 1ns / 100ps

module triangle_simplex_point_query_unit_test
    import tspq_pkg::*;
;

    localparam int CB = 16;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic signed [CB-1:0] cx;
        logic signed [CB-1:0] cy;
        logic                 in_res;
        logic [1:0]           count;
    } t_answer;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [1:0]           i_kind;
    logic signed [CB-1:0] i_x_coord;
    logic signed [CB-1:0] i_y_coord;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic signed [CB-1:0] o_closest_x;
    logic signed [CB-1:0] o_closest_y;
    logic                 o_inside_res;
    logic [1:0]           o_vertex_count;

    longint  win_x [3];
    longint  win_y [3];
    int      win_count;
    t_answer answers_due [$];
    int      mismatches;
    int      quiet_cycles;
    bit      hold_receiver;
    int      hold_cycles;
    int      out_wait;

    triangle_simplex_point_query_unit #(.COORD_BITS(CB)) u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Exact integer projection, truncated toward zero
    function automatic void project_onto(input longint ax, input longint ay,
                                         input longint bx, input longint by,
                                         input longint px, input longint py,
                                         output longint rx, output longint ry);
        longint dx, dy, t, l2;
        dx = bx - ax;
        dy = by - ay;
        t  = dx * (px - ax) + dy * (py - ay);
        l2 = dx * dx + dy * dy;
        if (l2 <= t) begin
            rx = bx;
            ry = by;
        end else if (t <= 0) begin
            rx = ax;
            ry = ay;
        end else begin
            rx = ax + (dx * t) / l2;
            ry = ay + (dy * t) / l2;
        end
    endfunction

    function automatic int sign_of_cross(input int ia, input int ib,
                                         input longint px, input longint py);
        longint c;
        c = (win_x[ib] - win_x[ia]) * (py - win_y[ia])
          - (win_y[ib] - win_y[ia]) * (px - win_x[ia]);
        return c > 0 ? 1 : (c < 0 ? -1 : 0);
    endfunction

    function automatic t_answer answer_query(input logic [1:0] kind,
                                             input longint px, input longint py);
        t_answer a;
        longint  rx, ry, cx, cy, dot, dx, dy;
        int      s0, s;
        a = '0;
        a.count = win_count[1:0];
        rx = 0;
        ry = 0;
        if (kind == KIND_CLOSEST) begin
            if (win_count == 1) begin
                rx = win_x[0];
                ry = win_y[0];
            end else if (win_count == 2) begin
                project_onto(win_x[0], win_y[0], win_x[1], win_y[1], px, py, rx, ry);
            end else if (win_count == 3) begin
                project_onto(win_x[2], win_y[2], win_x[0], win_y[0], px, py, rx, ry);
                for (int i = 0; i < 2; i++) begin
                    project_onto(win_x[i], win_y[i], win_x[i+1], win_y[i+1], px, py, cx, cy);
                    if ((rx-px)*(rx-px) + (ry-py)*(ry-py) > (cx-px)*(cx-px) + (cy-py)*(cy-py)) begin
                        rx = cx;
                        ry = cy;
                    end
                end
            end
            a.cx = rx[CB-1:0];
            a.cy = ry[CB-1:0];
        end else begin
            if (win_count == 1) begin
                a.in_res = (px == win_x[0] && py == win_y[0]);
            end else if (win_count == 2) begin
                dx = win_x[1] - win_x[0];
                dy = win_y[1] - win_y[0];
                dot = dx * (px - win_x[0]) + dy * (py - win_y[0]);
                a.in_res = sign_of_cross(0, 1, px, py) == 0 && dot >= 0
                           && dot <= dx * dx + dy * dy;
            end else if (win_count == 3) begin
                s0 = sign_of_cross(2, 0, px, py);
                a.in_res = 1'b1;
                for (int i = 0; i < 2; i++) begin
                    s = sign_of_cross(i, i + 1, px, py);
                    if (s == 0) break;
                    if (s != s0) begin
                        a.in_res = 1'b0;
                        break;
                    end
                end
            end
        end
        return a;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic send_item(input logic [1:0] kind, input logic signed [CB-1:0] x,
                             input logic signed [CB-1:0] y);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_x_coord  <= x;
        i_y_coord  <= y;
        do @(posedge i_clk); while (!o_in_ready);
        if (kind == KIND_ADD) begin
            if (win_count == 3) begin
                win_x[0] = win_x[1]; win_y[0] = win_y[1];
                win_x[1] = win_x[2]; win_y[1] = win_y[2];
                win_count = 2;
            end
            win_x[win_count] = x;
            win_y[win_count] = y;
            win_count++;
        end else if (kind != KIND_UNUSED) begin
            answers_due.push_back(answer_query(kind, x, y));
        end
    endtask

    function automatic logic signed [CB-1:0] rand_coord(input int span);
        case ($urandom_range(0, 5))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return CB'($urandom_range(0, 2 * span) - span);
            default: return CB'($urandom());
        endcase
    endfunction

    always @(posedge i_clk) begin
        int w;
        w = $urandom_range(0, 16);
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_ready <= 1'b0;
        end else if (hold_receiver) begin
            hold_cycles <= 300;
            i_out_ready <= 1'b0;
        end else if (o_out_valid && i_out_ready) begin
            out_wait    <= w;
            i_out_ready <= (w == 0);
        end else if (out_wait > 0) begin
            out_wait    <= out_wait - 1;
            i_out_ready <= (out_wait == 1);
        end else begin
            i_out_ready <= 1'b1;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (answers_due.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                if (o_closest_x !== answers_due[0].cx)
                    report_mismatch($sformatf("closest_x %0d exp %0d",
                                              o_closest_x, answers_due[0].cx));
                if (o_closest_y !== answers_due[0].cy)
                    report_mismatch($sformatf("closest_y %0d exp %0d",
                                              o_closest_y, answers_due[0].cy));
                if (o_inside_res !== answers_due[0].in_res)
                    report_mismatch($sformatf("inside_res %0b exp %0b",
                                              o_inside_res, answers_due[0].in_res));
                if (o_vertex_count !== answers_due[0].count)
                    report_mismatch($sformatf("vertex_count %0d exp %0d",
                                              o_vertex_count, answers_due[0].count));
                void'(answers_due.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic test_empty_window();
        send_item(KIND_CLOSEST, 16'sd100, -16'sd5);
        send_item(KIND_CONTAIN, 16'sd0, 16'sd0);
        send_item(KIND_UNUSED, 16'sd1, 16'sd1);
    endtask

    task automatic test_one_and_two();
        send_item(KIND_ADD, 16'sh7fff, 16'sh8000);
        send_item(KIND_CLOSEST, 16'sd0, 16'sd0);
        send_item(KIND_CONTAIN, 16'sh7fff, 16'sh8000);
        send_item(KIND_CONTAIN, 16'sd1, 16'sd0);
        send_item(KIND_ADD, 16'sh7fff, 16'sh8000);
        send_item(KIND_CLOSEST, 16'sd3, 16'sd3);
        send_item(KIND_CONTAIN, -16'sd9, 16'sd4);
        send_item(KIND_ADD, 16'sh8000, 16'sh7fff);
        send_item(KIND_CLOSEST, 16'sd0, 16'sd1);
        send_item(KIND_CLOSEST, 16'sh7fff, 16'sh7fff);
        send_item(KIND_CONTAIN, -16'sd1, 16'sd0);
    endtask

    task automatic test_triangle();
        send_item(KIND_ADD, 16'sd0, 16'sd0);
        send_item(KIND_ADD, 16'sd0, 16'sd0);
        send_item(KIND_ADD, 16'sd10, 16'sd0);
        send_item(KIND_ADD, 16'sd0, 16'sd10);
        send_item(KIND_CLOSEST, 16'sd20, 16'sd20);
        send_item(KIND_CLOSEST, -16'sd7, 16'sd3);
        send_item(KIND_CONTAIN, 16'sd2, 16'sd2);
        send_item(KIND_CONTAIN, 16'sd5, 16'sd5);
        send_item(KIND_CONTAIN, 16'sd0, 16'sd4);
        send_item(KIND_CONTAIN, 16'sd20, 16'sd1);
        send_item(KIND_CONTAIN, -16'sd3, 16'sd20);
    endtask

    task automatic test_backpressure();
        hold_receiver <= 1'b1;
        @(posedge i_clk);
        hold_receiver <= 1'b0;
        for (int i = 0; i < 6; i++)
            send_item(KIND_CLOSEST, rand_coord(50), rand_coord(50));
    endtask

    task automatic test_random(input int items);
        int span;
        logic [1:0] kind;
        for (int i = 0; i < items; i++) begin
            if (i % 100 == 0) span = $urandom_range(0, 1) ? 40 : 32767;
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5: kind = KIND_ADD;
                6, 7, 8, 9, 10, 11: kind = KIND_CLOSEST;
                19:      kind = KIND_UNUSED;
                default: kind = KIND_CONTAIN;
            endcase
            send_item(kind, rand_coord(span), rand_coord(span));
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_kind        = KIND_ADD;
        i_x_coord     = '0;
        i_y_coord     = '0;
        i_out_ready   = 1'b0;
        hold_receiver = 1'b0;
        hold_cycles   = 0;
        out_wait      = 0;
        mismatches    = 0;
        quiet_cycles  = 0;
        win_count     = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_window();
        test_one_and_two();
        test_triangle();
        test_backpressure();
        test_random(1020);
        i_in_valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && answers_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/tspq_pkg.sv
rtl/tspq_muldiv.sv
rtl/triangle_simplex_point_query_unit.sv
rtl/tspq_checker.sv
bench/triangle_simplex_point_query_unit_test.sv
